FILE: hw/rtl/sktis_pkg.sv
// types, codes and defaults shared by the sorted key table and its cells
`default_nettype none

package sktis_pkg;

  localparam int DEF_CAPACITY = 256;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_FIND   = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2,
    STATUS_RSVD  = 2'd3
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] key;
    logic [15:0]        payload;
    logic [7:0]         position;
  } in_item_t;

  typedef struct packed {
    logic [8:0]         index;
    logic signed [15:0] entry_key;
    logic [15:0]        entry_payload;
    logic [8:0]         count;
    status_t            status;
  } out_item_t;

  typedef struct packed {
    logic               cmp_en;
    logic               ins_en;
    logic signed [15:0] key;
    logic [15:0]        payload;
    logic [7:0]         position;
  } cell_cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sktis_cell.sv
// one table slot: holds an entry, compares it with the query and shifts from its left neighbor
`default_nettype none

module sktis_cell #(
  parameter int IDX = 0,
  parameter int CW  = 9,
  parameter int PW  = 9
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  sktis_pkg::cell_cmd_t     cmd,
  input  wire  [CW-1:0]            count,
  input  wire  signed [15:0]       left_key,
  input  wire  [15:0]              left_pay,
  input  wire                      left_lt,
  output logic signed [15:0]       key_q,
  output logic [15:0]              pay_q,
  output logic                     lt_q,
  output logic                     hit,
  output logic signed [15:0]       rd_key,
  output logic [15:0]              rd_pay
);

  localparam logic [CW-1:0] MY_POS = CW'(IDX);
  localparam logic [PW-1:0] MY_RD  = PW'(IDX);

  logic signed [15:0] key_r;
  logic [15:0]        pay_r;
  logic               lt_r;
  logic               sel_r;

  // lower-bound flags and read select, registered in the compare step ahead of execution
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r  <= 1'b0;
      sel_r <= 1'b0;
    end else if (cmd.cmp_en) begin
      lt_r  <= (MY_POS < count) && (key_r < cmd.key);
      sel_r <= (MY_RD == PW'(cmd.position));
    end
  end

  // slots past the bound take the left entry, the bound slot takes the new one
  always_ff @(posedge clk) begin
    if (cmd.ins_en && !lt_r) begin
      if (left_lt) begin
        key_r <= cmd.key;
        pay_r <= cmd.payload;
      end else begin
        key_r <= left_key;
        pay_r <= left_pay;
      end
    end
  end

  assign key_q  = key_r;
  assign pay_q  = pay_r;
  assign lt_q   = lt_r;
  assign hit    = left_lt && !lt_r;
  assign rd_key = sel_r ? key_r : 16'sd0;
  assign rd_pay = sel_r ? pay_r : 16'd0;

endmodule

`default_nettype wire

FILE: hw/rtl/sorted_key_table_insert_search.sv
// top level of the sorted key table: sequencer, fill count and the row of cells
//
//  channel  | ports                          | moves
//  ---------+--------------------------------+-------------------------------
//  input    | in_valid, in_ready, in_data    | one command per transfer
//  result   | out_valid, out_ready, out_data | one result per command
//
// each command passes from transfer to result through latch, compare in all cells,
// then shift or read, and the next command is taken only after that result is written
// a command is taken while the previous result still waits in the output register
// the execute step holds while that register is full, leaving the table unchanged
// rst_n clears the fill count and the sequencer; no clearing pass is made
`default_nettype none

module sorted_key_table_insert_search #(
  parameter int CAPACITY = sktis_pkg::DEF_CAPACITY
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  sktis_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output sktis_pkg::out_item_t out_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 8) ? CW : 8;
  localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_EXEC = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  sktis_pkg::in_item_t  item_r;
  logic [CW-1:0]        fill_r, fill_nxt;
  sktis_pkg::out_item_t out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;
  sktis_pkg::cell_cmd_t cmd;
  logic                 commit;

  logic signed [15:0] key_q  [CAPACITY];
  logic [15:0]        pay_q  [CAPACITY];
  logic               lt_q   [CAPACITY];
  logic               hit    [CAPACITY];
  logic signed [15:0] rd_key [CAPACITY];
  logic [15:0]        rd_pay [CAPACITY];

  logic [CW-1:0]      bound;
  logic signed [15:0] sel_key;
  logic [15:0]        sel_pay;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign commit    = (state_r == ST_EXEC) && (!out_valid_r || out_ready);

  always_comb begin
    cmd.cmp_en   = (state_r == ST_CMP);
    cmd.ins_en   = commit && (item_r.kind == sktis_pkg::KIND_INSERT) &&
                   (fill_r != FULL_COUNT);
    cmd.key      = item_r.key;
    cmd.payload  = item_r.payload;
    cmd.position = item_r.position;
  end

  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic signed [15:0] lkey;
    logic [15:0]        lpay;
    logic               llt;
    if (gi == 0) begin : g_first
      assign lkey = 16'sd0;
      assign lpay = 16'd0;
      assign llt  = 1'b1;
    end else begin : g_rest
      assign lkey = key_q[gi-1];
      assign lpay = pay_q[gi-1];
      assign llt  = lt_q[gi-1];
    end
    sktis_cell #(
      .IDX (gi),
      .CW  (CW),
      .PW  (PW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .count    (fill_r),
      .left_key (lkey),
      .left_pay (lpay),
      .left_lt  (llt),
      .key_q    (key_q[gi]),
      .pay_q    (pay_q[gi]),
      .lt_q     (lt_q[gi]),
      .hit      (hit[gi]),
      .rd_key   (rd_key[gi]),
      .rd_pay   (rd_pay[gi])
    );
  end

  // bound position and read data from the row
  always_comb begin
    bound   = lt_q[CAPACITY-1] ? FULL_COUNT : '0;
    sel_key = 16'sd0;
    sel_pay = 16'd0;
    for (int i = 0; i < CAPACITY; i++) begin
      bound   = bound | (hit[i] ? CW'(i) : '0);
      sel_key = sel_key | rd_key[i];
      sel_pay = sel_pay | rd_pay[i];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (commit) begin
          state_nxt             = ST_IDLE;
          out_valid_nxt         = 1'b1;
          out_nxt.index         = 9'd0;
          out_nxt.entry_key     = 16'sd0;
          out_nxt.entry_payload = 16'd0;
          out_nxt.status        = sktis_pkg::STATUS_OK;
          unique case (item_r.kind)
            sktis_pkg::KIND_INSERT: begin
              if (fill_r == FULL_COUNT) begin
                out_nxt.status = sktis_pkg::STATUS_FULL;
              end else begin
                fill_nxt      = fill_r + CW'(1);
                out_nxt.index = 9'(bound);
              end
            end
            sktis_pkg::KIND_FIND: begin
              out_nxt.index = 9'(bound);
            end
            sktis_pkg::KIND_CLEAR: begin
              fill_nxt = '0;
            end
            sktis_pkg::KIND_READ: begin
              out_nxt.index = 9'(item_r.position);
              if (PW'(item_r.position) < PW'(fill_r)) begin
                out_nxt.entry_key     = sel_key;
                out_nxt.entry_payload = sel_pay;
              end else begin
                out_nxt.status = sktis_pkg::STATUS_RANGE;
              end
            end
            default: begin
            end
          endcase
          out_nxt.count = 9'(fill_nxt);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

endmodule

`default_nettype wire
